// File: rtl/stereo_feedback_echo_assert.svh
// ---------------------------------------------------------------------------
// Stereo feedback echo assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_ECHO_ASSERT_SVH
`define STEREO_FEEDBACK_ECHO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be true.
`define SFE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/sfe_pkg.sv
// ---------------------------------------------------------------------------
// Stereo feedback echo package
// Field widths, register codes and reset values, and the sequencer types.
// ---------------------------------------------------------------------------
package sfe_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 14;
    localparam int COEF_W     = 15;
    localparam int ACC_W      = 32;
    localparam int HALF_SHIFT = 16;

    // Register reset values.
    localparam logic [DELAY_W-1:0] DELAY_RST = 14'd9600;
    localparam logic [COEF_W-1:0]  ALPHA_RST = 15'd19661;
    localparam logic [COEF_W-1:0]  BETA_RST  = 15'd19661;
    localparam logic [COEF_W-1:0]  NORM_RST  = 15'd16384;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DELAY = 2'd0,
        CFG_ALPHA = 2'd1,
        CFG_BETA  = 2'd2,
        CFG_NORM  = 2'd3
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_ECHO,
        S_FEED,
        S_WRITE,
        S_OUT
    } state_t;

    // Operand selection for the shared multiplier.
    typedef enum logic [1:0] {
        MUL_X,
        MUL_S,
        MUL_B
    } mul_sel_t;

    // Operand selection for the shared saturating adder.
    typedef enum logic {
        ADD_Y,
        ADD_D
    } add_sel_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic     rd_en;
        logic     ld_x;
        logic     ld_s;
        logic     ld_feed;
        logic     commit;
        logic     ld_out;
        mul_sel_t mul_sel;
        add_sel_t add_sel;
    } ctrl_t;

endpackage

// File: rtl/sfe_ram.sv
// ---------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sfe_alu.sv
// ---------------------------------------------------------------------------
// Stereo feedback echo arithmetic unit
// Shared Q15 doubling multiplier with saturation and a saturating adder.
// ---------------------------------------------------------------------------
module sfe_alu (
    input  logic signed [sfe_pkg::SAMPLE_W-1:0] mul_a,
    input  logic signed [sfe_pkg::SAMPLE_W-1:0] mul_b,
    output logic signed [sfe_pkg::ACC_W-1:0]    mul_q,
    input  logic signed [sfe_pkg::ACC_W-1:0]    add_a,
    input  logic signed [sfe_pkg::ACC_W-1:0]    add_b,
    output logic signed [sfe_pkg::ACC_W-1:0]    add_q
);

    localparam logic [sfe_pkg::ACC_W-1:0] POS_MAX = {1'b0, {(sfe_pkg::ACC_W-1){1'b1}}};
    localparam logic [sfe_pkg::ACC_W-1:0] NEG_MAX = {1'b1, {(sfe_pkg::ACC_W-1){1'b0}}};
    // The only product whose double overflows: minus one times minus one.
    localparam logic [sfe_pkg::ACC_W-1:0] PROD_OVF = {2'b01, {(sfe_pkg::ACC_W-2){1'b0}}};

    logic signed [sfe_pkg::ACC_W-1:0] prod;
    logic        [sfe_pkg::ACC_W:0]   sum;

    // Signed product, doubled, with the single overflow case clamped.
    always_comb
    begin
        prod = mul_a * mul_b;
        if (prod == PROD_OVF)
        begin
            mul_q = POS_MAX;
        end
        else
        begin
            mul_q = prod <<< 1;
        end
    end

    // Sum with one guard bit, saturated to the accumulator range.
    always_comb
    begin
        sum = {add_a[sfe_pkg::ACC_W-1], add_a} + {add_b[sfe_pkg::ACC_W-1], add_b};
        if (sum[sfe_pkg::ACC_W] != sum[sfe_pkg::ACC_W-1])
        begin
            add_q = sum[sfe_pkg::ACC_W] ? NEG_MAX : POS_MAX;
        end
        else
        begin
            add_q = sum[sfe_pkg::ACC_W-1:0];
        end
    end

endmodule

// File: rtl/sfe_ctrl.sv
// ---------------------------------------------------------------------------
// Stereo feedback echo sequencer
// Steps one item through read, three products, two sums and write-back.
// ---------------------------------------------------------------------------
module sfe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_busy,
    output logic           in_stall,
    output sfe_pkg::ctrl_t ctrl
);

    sfe_pkg::state_t state_reg;
    sfe_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfe_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfe_pkg::S_ADDR;
                end
            end
            sfe_pkg::S_ADDR:  state_next = sfe_pkg::S_ECHO;
            sfe_pkg::S_ECHO:  state_next = sfe_pkg::S_FEED;
            sfe_pkg::S_FEED:  state_next = sfe_pkg::S_WRITE;
            sfe_pkg::S_WRITE: state_next = out_busy ? sfe_pkg::S_OUT : sfe_pkg::S_IDLE;
            sfe_pkg::S_OUT:
            begin
                if (!out_busy)
                begin
                    state_next = sfe_pkg::S_IDLE;
                end
            end
            default: state_next = sfe_pkg::S_IDLE;
        endcase
    end

    // Strobes for the datapath.
    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = sfe_pkg::MUL_X;
        ctrl.add_sel = sfe_pkg::ADD_Y;
        in_stall     = 1'b1;
        case (state_reg)
            sfe_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
            end
            sfe_pkg::S_ADDR:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.ld_x    = 1'b1;
                ctrl.mul_sel = sfe_pkg::MUL_X;
            end
            sfe_pkg::S_ECHO:
            begin
                ctrl.ld_s    = 1'b1;
                ctrl.mul_sel = sfe_pkg::MUL_S;
            end
            sfe_pkg::S_FEED:
            begin
                ctrl.ld_feed = 1'b1;
                ctrl.mul_sel = sfe_pkg::MUL_B;
                ctrl.add_sel = sfe_pkg::ADD_Y;
            end
            sfe_pkg::S_WRITE:
            begin
                ctrl.commit  = 1'b1;
                ctrl.add_sel = sfe_pkg::ADD_D;
                ctrl.ld_out  = !out_busy;
            end
            sfe_pkg::S_OUT:
            begin
                ctrl.ld_out = !out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/stereo_feedback_echo.sv
// ---------------------------------------------------------------------------
// Stereo feedback echo: one Q15 sample in, one Q15 sample with echo out.
// After accept each item passes ADDR, ECHO, FEED and WRITE, with one RAM read
// and three shared products; the next is taken in IDLE, later if out_stall holds.
// Reset loads register defaults and zeroes write positions; unwritten words read 0.
// ---------------------------------------------------------------------------
module stereo_feedback_echo #(
    parameter int LINE_DEPTH = 16384,
    parameter int CHANNELS   = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [sfe_pkg::COEF_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sfe_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                chan,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sfe_pkg::SAMPLE_W-1:0] sample_out
);

    // Line words read as zero until written: a per-channel wrap flag and the
    // write position tell which words hold data, so no clearing pass is run.

    localparam int PW       = $clog2(LINE_DEPTH);
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_D    = CHANNELS * LINE_DEPTH;
    localparam int RAM_AW   = $clog2(RAM_D);
    localparam int CW       = ((PW > sfe_pkg::DELAY_W) ? PW : sfe_pkg::DELAY_W) + 1;
    localparam logic [CW-1:0]     DLY_MAX = CW'(LINE_DEPTH - 1);
    localparam logic [CW-1:0]     LD_C    = CW'(LINE_DEPTH);
    localparam logic [PW:0]       LD_P    = (PW + 1)'(LINE_DEPTH);
    localparam logic [RAM_AW-1:0] LD_A    = RAM_AW'(LINE_DEPTH);

    localparam int SW = sfe_pkg::SAMPLE_W;
    localparam int AW = sfe_pkg::ACC_W;

    // Configuration registers.
    logic [sfe_pkg::DELAY_W-1:0] delay_reg;
    logic [sfe_pkg::COEF_W-1:0]  alpha_reg;
    logic [sfe_pkg::COEF_W-1:0]  beta_reg;
    logic [sfe_pkg::COEF_W-1:0]  norm_reg;

    // Item and channel state.
    logic signed [SW-1:0] sample_reg;
    logic [CH_W-1:0]      ch_reg;
    logic [PW-1:0]        wp_reg [CHANNELS];
    logic [CHANNELS-1:0]  wrap_reg;
    logic                 echo_ok_reg;

    // Intermediate products and sums.
    logic signed [AW-1:0] x_reg;
    logic signed [AW-1:0] s_reg;
    logic signed [AW-1:0] bs_reg;
    logic signed [AW-1:0] y_reg;

    // Result register.
    logic                 out_valid_reg;
    logic signed [SW-1:0] sample_out_reg;

    sfe_pkg::ctrl_t       ctrl;
    logic                 in_accept;
    logic                 out_busy;
    logic [PW-1:0]        wp_cur;
    logic [PW:0]          wp_inc;
    logic [PW-1:0]        wp_next;
    logic [CW-1:0]        dly_c;
    logic [CW-1:0]        wp_ext;
    logic [CW-1:0]        rp_full;
    logic [PW-1:0]        rp;
    logic [RAM_AW-1:0]    ch_base;
    logic [RAM_AW-1:0]    rd_addr;
    logic [RAM_AW-1:0]    wr_addr;
    logic [SW-1:0]        ram_rdata;
    logic signed [SW-1:0] echo;
    logic signed [SW-1:0] mul_a;
    logic signed [SW-1:0] mul_b;
    logic signed [AW-1:0] mul_q;
    logic signed [AW-1:0] add_b;
    logic signed [AW-1:0] add_q;

    assign in_accept = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= sfe_pkg::DELAY_RST;
            alpha_reg <= sfe_pkg::ALPHA_RST;
            beta_reg  <= sfe_pkg::BETA_RST;
            norm_reg  <= sfe_pkg::NORM_RST;
        end
        else if (cfg_we)
        begin
            case (sfe_pkg::cfg_idx_t'(cfg_index))
                sfe_pkg::CFG_DELAY: delay_reg <= cfg_data[sfe_pkg::DELAY_W-1:0];
                sfe_pkg::CFG_ALPHA: alpha_reg <= cfg_data;
                sfe_pkg::CFG_BETA:  beta_reg  <= cfg_data;
                sfe_pkg::CFG_NORM:  norm_reg  <= cfg_data;
                default:            delay_reg <= delay_reg;
            endcase
        end
    end

    // Capture the accepted item; the channel is forced to zero for a single channel.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample_in;
            ch_reg     <= (CHANNELS == 1) ? '0 : CH_W'(chan);
        end
    end

    // Read position: the clamped delay behind the write position, circular.
    always_comb
    begin
        wp_cur  = wp_reg[ch_reg];
        dly_c   = (CW'(delay_reg) > DLY_MAX) ? DLY_MAX : CW'(delay_reg);
        wp_ext  = CW'(wp_cur);
        rp_full = (wp_ext >= dly_c) ? (wp_ext - dly_c) : (wp_ext + LD_C - dly_c);
        rp      = rp_full[PW-1:0];
        ch_base = RAM_AW'(ch_reg) * LD_A;
        rd_addr = ch_base + RAM_AW'(rp);
        wr_addr = ch_base + RAM_AW'(wp_cur);
        wp_inc  = (PW + 1)'(wp_cur) + (PW + 1)'(1);
        wp_next = (wp_inc == LD_P) ? '0 : wp_inc[PW-1:0];
    end

    // A word holds data once its channel has wrapped or it lies below wp.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            echo_ok_reg <= wrap_reg[ch_reg] || (rp < wp_cur);
        end
    end

    // Write positions and wrap flags advance once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
            wrap_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            wp_reg[ch_reg] <= wp_next;
            if (wp_inc == LD_P)
            begin
                wrap_reg[ch_reg] <= 1'b1;
            end
        end
    end

    // Delay lines of all channels in one memory.
    sfe_ram #(
        .WIDTH (SW),
        .DEPTH (RAM_D)
    ) u_line (
        .clk   (clk),
        .we    (ctrl.commit),
        .waddr (wr_addr),
        .wdata (add_q[AW-1:sfe_pkg::HALF_SHIFT]),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign echo = echo_ok_reg ? ram_rdata : '0;

    // Operand selection for the shared unit.
    always_comb
    begin
        case (ctrl.mul_sel)
            sfe_pkg::MUL_X:
            begin
                mul_a = sample_reg;
                mul_b = {1'b0, norm_reg};
            end
            sfe_pkg::MUL_S:
            begin
                mul_a = {1'b0, alpha_reg};
                mul_b = echo;
            end
            sfe_pkg::MUL_B:
            begin
                mul_a = {1'b0, beta_reg};
                mul_b = s_reg[AW-1:sfe_pkg::HALF_SHIFT];
            end
            default:
            begin
                mul_a = sample_reg;
                mul_b = {1'b0, norm_reg};
            end
        endcase
        case (ctrl.add_sel)
            sfe_pkg::ADD_Y: add_b = s_reg;
            sfe_pkg::ADD_D: add_b = bs_reg;
            default:        add_b = s_reg;
        endcase
    end

    sfe_alu u_alu (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_q (mul_q),
        .add_a (x_reg),
        .add_b (add_b),
        .add_q (add_q)
    );

    // Product and sum registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_x)
        begin
            x_reg <= mul_q;
        end
        if (ctrl.ld_s)
        begin
            s_reg <= mul_q;
        end
        if (ctrl.ld_feed)
        begin
            bs_reg <= mul_q;
            y_reg  <= add_q;
        end
    end

    sfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_out)
        begin
            sample_out_reg <= y_reg[AW-1:sfe_pkg::HALF_SHIFT];
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // Checks on the sequencer and datapath.
    `include "stereo_feedback_echo_assert.svh"

    `SFE_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "input taken while busy")
    `SFE_ASSERT_NEVER(a_rw_overlap, ctrl.rd_en && ctrl.commit, "read and write-back overlap")
    `SFE_ASSERT_IMP(a_out_free, ctrl.ld_out, !out_busy, "result loaded over a pending item")
    `SFE_ASSERT_IMP(a_wp_range, ctrl.commit, (PW + 1)'(wp_cur) < LD_P, "write position out of range")

endmodule

// File: tb/stereo_feedback_echo_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Stereo feedback echo testbench
// Sends Q15 samples on both channels with random bursts and output stalls,
// predicts every output sample from a local copy of both delay lines and
// the gain registers, and compares the results in order. Gain and delay
// settings change between phases while the block is idle. A final phase
// uses the longest delay, where the delayed words are still unwritten.
// ---------------------------------------------------------------------------
module stereo_feedback_echo_test;

    localparam int SW            = sfe_pkg::SAMPLE_W;
    localparam int LINE_DEPTH    = 16384;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 100000;
    localparam int REPORT_LIMIT  = 50;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 ch;
    } echo_item_t;

    typedef enum {LANE_LEFT, LANE_RIGHT, LANE_BOTH} lane_mode_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_kind_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [1:0]                      cfg_index = sfe_pkg::CFG_DELAY;
    logic [sfe_pkg::COEF_W-1:0]      cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic signed [SW-1:0]            sample_in = '0;
    logic                            chan      = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic signed [SW-1:0]            sample_out;

    // Predictor state: gain and delay registers, delay lines, write positions.
    int                         dly_reg;
    int                         alpha_reg;
    int                         beta_reg;
    int                         norm_reg;
    logic signed [SW-1:0]       line_mem [2][LINE_DEPTH];
    int                         wr_ptr [2];

    echo_item_t                 pending_items [$];
    logic signed [SW-1:0]       expected_out [$];
    int                         items_queued;
    int                         results_seen;
    int                         mismatches;

    // Idling controls set per phase.
    int                         gap_max;
    int                         stall_level;
    int                         hold_asked;
    int                         hold_served;

    int                         burst_left;
    int                         gap_left;
    echo_item_t                 next_item;
    int                         hold_left;
    int                         stretch_left;
    stall_kind_t                stall_kind;
    int                         quiet_cycles;
    logic signed [SW-1:0]       want;

    stereo_feedback_echo uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .chan       (chan),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Saturate to the signed 32-bit range.
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Doubled Q15 product, saturated.
    function automatic longint scaled(longint a, longint b);
        return clamp32(a * b * 2);
    endfunction

    // Upper 16 bits of a 32-bit value, sign extended.
    function automatic longint top_half(longint v);
        logic [31:0] w;
        w = v[31:0];
        return longint'($signed(w[31:16]));
    endfunction

    // One echo step: read the delayed word, form output and feedback words.
    function automatic logic signed [SW-1:0] echo_step(
        logic signed [SW-1:0] smp, logic ch);
        int     wp;
        int     rp;
        int     dly;
        longint echo_w;
        longint x;
        longint s;
        longint y;
        longint bs;
        longint d;
        wp = wr_ptr[ch];
        dly = (dly_reg > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : dly_reg;
        rp = (wp + LINE_DEPTH - dly) % LINE_DEPTH;
        echo_w = longint'(line_mem[ch][rp]);
        x = scaled(longint'(smp), longint'(norm_reg));
        s = scaled(longint'(alpha_reg), echo_w);
        y = clamp32(x + s);
        bs = scaled(longint'(beta_reg), top_half(s));
        d = clamp32(x + bs);
        line_mem[ch][wp] = SW'(top_half(d));
        wr_ptr[ch] = (wp + 1) % LINE_DEPTH;
        return SW'(top_half(y));
    endfunction

    // Sample values weighted toward the extremes and toward small values.
    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2, 3: v = SW'(int'($urandom_range(0, 64)) - 32);
            default: v = SW'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_item(logic signed [SW-1:0] smp, logic ch);
        echo_item_t it;
        it.smp = smp;
        it.ch = ch;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_random(int n, lane_mode_t lane);
        logic ch;
        for (int i = 0; i < n; i++)
        begin
            case (lane)
                LANE_LEFT: ch = 1'b0;
                LANE_RIGHT: ch = 1'b1;
                default: ch = 1'($urandom_range(0, 1));
            endcase
            push_item(pick_sample(), ch);
        end
    endtask

    // Register write; the predictor copy keeps only the register's width.
    task automatic write_reg(sfe_pkg::cfg_idx_t idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[sfe_pkg::COEF_W-1:0];
        case (idx)
            sfe_pkg::CFG_DELAY: dly_reg = value & 32'h3FFF;
            sfe_pkg::CFG_ALPHA: alpha_reg = value & 32'h7FFF;
            sfe_pkg::CFG_BETA: beta_reg = value & 32'h7FFF;
            default: norm_reg = value & 32'h7FFF;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(int dly, int alpha, int beta, int norm);
        write_reg(sfe_pkg::CFG_DELAY, dly);
        write_reg(sfe_pkg::CFG_ALPHA, alpha);
        write_reg(sfe_pkg::CFG_BETA, beta);
        write_reg(sfe_pkg::CFG_NORM, norm);
    endtask

    // Wait until every queued item has produced its result, then a margin.
    task automatic settle();
        while (results_seen != items_queued)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Sender: bursts of random length with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_in <= '0;
            chan <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_out.push_back(echo_step(sample_in, chan));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0 && gap_max > 0 && $urandom_range(0, 2) != 0)
                    gap_left = $urandom_range(1, gap_max);
            end
            // A stalled item stays on the port unchanged.
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    in_valid <= 1'b1;
                    sample_in <= next_item.smp;
                    chan <= next_item.ch;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stretches of different stall patterns, plus long hold-offs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            stretch_left = 0;
            stall_kind = STALL_NONE;
        end
        else
        begin
            if (hold_asked != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_level == 0)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(4, 40);
                    stall_kind = stall_kind_t'($urandom_range(0, 3));
                end
                stretch_left--;
                case (stall_kind)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= !out_stall;
                endcase
            end
        end
    end

    // Result checker: each output item against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $error("sample_out: no result expected, got %0d", sample_out);
            end
            else
            begin
                want = expected_out.pop_front();
                if (sample_out !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want, sample_out);
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        dly_reg = int'(sfe_pkg::DELAY_RST);
        alpha_reg = int'(sfe_pkg::ALPHA_RST);
        beta_reg = int'(sfe_pkg::BETA_RST);
        norm_reg = int'(sfe_pkg::NORM_RST);
        wr_ptr[0] = 0;
        wr_ptr[1] = 0;
        for (int c = 0; c < 2; c++)
            for (int i = 0; i < LINE_DEPTH; i++)
                line_mem[c][i] = '0;
        items_queued = 0;
        results_seen = 0;
        mismatches = 0;
        gap_max = 4;
        stall_level = 1;
        hold_asked = 0;
        hold_served = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sample extremes on both channels.
        push_item(16'sh7FFF, 1'b0);
        push_item(16'sh8000, 1'b0);
        push_item(16'sh0000, 1'b0);
        push_item(-16'sd1, 1'b0);
        push_item(16'sd1, 1'b0);
        push_item(16'sh8000, 1'b1);
        push_item(16'sh7FFF, 1'b1);
        settle();

        // Full gains and a short delay: feedback builds up until sums saturate.
        setup(2, 32767, 32767, 32767);
        for (int i = 0; i < 6; i++)
            push_item(16'sh8000, 1'b0);
        for (int i = 0; i < 4; i++)
            push_item(16'sh7FFF, 1'b0);
        for (int i = 0; i < 3; i++)
            push_item(16'sh7FFF, 1'b1);
        push_item(16'sd1, 1'b0);
        settle();

        // Random phases over a range of settings.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: setup(0, $urandom_range(0, 32767), $urandom_range(0, 32767),
                         $urandom_range(0, 32767));
                1: setup(1, 32767, 32767, 32767);
                2: setup($urandom_range(2, 40), 0, 32767, 32767);
                // Bit 14 of the data bus is set; the delay register drops it.
                3: setup(16384 + $urandom_range(0, 20), 32767, 0,
                         $urandom_range(0, 32767));
                4: setup($urandom_range(2, 60), 32767, 32767, 0);
                5: setup(16383, $urandom_range(0, 32767), $urandom_range(0, 32767),
                         $urandom_range(0, 32767));
                default: setup($urandom_range(0, 300), $urandom_range(0, 32767),
                               $urandom_range(0, 32767), $urandom_range(0, 32767));
            endcase
            gap_max = (phase % 4 == 1) ? 0 : ((phase % 2 == 1) ? 3 : 12);
            stall_level = (phase == 3) ? 0 : 1;
            case (phase)
                2: push_random(100, LANE_LEFT);
                4: push_random(100, LANE_RIGHT);
                default: push_random(100, LANE_BOTH);
            endcase
            // Hold the output long enough for the block to back up its input.
            if (phase == 5 || phase == 6)
                hold_asked++;
            settle();
        end

        // Longest delay: the delayed words have not been written yet.
        write_reg(sfe_pkg::CFG_DELAY, 16383);
        gap_max = 4;
        stall_level = 1;
        push_random(40, LANE_LEFT);
        settle();

        repeat (20) @(posedge clk);
        if (expected_out.size() != 0)
        begin
            mismatches++;
            $error("sample_out: %0d expected results never arrived",
                   expected_out.size());
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
